@@ src/twr_responder_frame_engine_assert.svh @@
// ----------------------------------------------------------------------------
// twr_responder_frame_engine_assert.svh
// Assertion macros shared by the responder frame engine checkers.
// ----------------------------------------------------------------------------
`ifndef TWR_RESPONDER_FRAME_ENGINE_ASSERT_SVH
`define TWR_RESPONDER_FRAME_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TWR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("twr assertion failed");

// next-cycle implication
`define TWR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("twr assertion failed");

`endif

@@ src/twr_pkg.sv @@
// ----------------------------------------------------------------------------
// twr_pkg
// Types, codes and constants of the two-way ranging responder frame engine.
// ----------------------------------------------------------------------------
package twr_pkg;

	localparam int RX_CAPACITY_DEF = 20;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int HDR_LEN         = 10;
	localparam int RESP_LEN        = 20;

	localparam logic [6:0] COUNT_MAX = 7'd127;

	localparam logic [7:0] FC_LO    = 8'h41;
	localparam logic [7:0] FC_HI    = 8'h88;
	localparam logic [7:0] POLL_FN  = 8'hE0;
	localparam logic [7:0] RESP_FN  = 8'hE1;

	localparam logic [15:0] PAN_ID_RST    = 16'd57034;
	localparam logic [31:0] OWN_ADDR_RST  = 32'd1163280727;
	localparam logic [31:0] PEER_ADDR_RST = 32'd1096238422;
	localparam logic [15:0] ANT_DELAY_RST = 16'd16456;
	localparam logic [15:0] REPLY_DLY_RST = 16'd5000;

	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_END     = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_ERROR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_RESP    = 2'd0,
		KIND_IGNORE  = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_PAN   = 3'd0,
		REG_OWN   = 3'd1,
		REG_PEER  = 3'd2,
		REG_ANT   = 3'd3,
		REG_DELAY = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] pan_id;
		logic [31:0] own_address;
		logic [31:0] peer_address;
		logic [15:0] antenna_delay;
		logic [15:0] reply_delay_uus;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [39:0] ts;
	} job_t;

endpackage

@@ src/twr_responder_frame_engine.sv @@
// ----------------------------------------------------------------------------
// twr_responder_frame_engine
// Responder side of single-sided two-way ranging: checks poll frames and
// emits the timed 20-byte response.
//
//  channel  handshake                       payload
//  in       in_valid / in_ready             command, rx_byte, rx_timestamp
//  out      out_valid / out_ready           kind, tx_byte, tx_time,
//                                           seq_number, last
//  cfg      psel/penable/pwrite/pready      paddr, pwdata, prdata
//
// Input items are taken one per cycle while the job queue has room.
// A valid poll gives 20 output items, one per cycle unless stalled, set by
// the byte sequencer of the response generator; other frame ends give
// one item. Job queue holds QUEUE_DEPTH frame closes; a stalled output
// fills it, then in_ready drops. Frame bytes alone never occupy the queue.
// Reset: async, registers return to defaults, sequence number is zero.
// ----------------------------------------------------------------------------
module twr_responder_frame_engine import twr_pkg::*; #(
	parameter int RX_CAPACITY = RX_CAPACITY_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  rx_byte,
	input  logic [39:0] rx_timestamp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic [32:0] tx_time,
	output logic [7:0]  seq_number,
	output logic        last
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;
	logic     full;
	logic     push;
	job_t     push_job;
	logic     pop;
	logic     pop_valid;
	job_t     pop_job;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pan_id          <= PAN_ID_RST;
			cfg_q.own_address     <= OWN_ADDR_RST;
			cfg_q.peer_address    <= PEER_ADDR_RST;
			cfg_q.antenna_delay   <= ANT_DELAY_RST;
			cfg_q.reply_delay_uus <= REPLY_DLY_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PAN:   cfg_q.pan_id          <= pwdata[15:0];
				REG_OWN:   cfg_q.own_address     <= pwdata;
				REG_PEER:  cfg_q.peer_address    <= pwdata;
				REG_ANT:   cfg_q.antenna_delay   <= pwdata[15:0];
				REG_DELAY: cfg_q.reply_delay_uus <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PAN:   prdata = {16'd0, cfg_q.pan_id};
			REG_OWN:   prdata = cfg_q.own_address;
			REG_PEER:  prdata = cfg_q.peer_address;
			REG_ANT:   prdata = {16'd0, cfg_q.antenna_delay};
			REG_DELAY: prdata = {16'd0, cfg_q.reply_delay_uus};
			default:   prdata = '0;
		endcase
	end

	twr_front #(
		.RX_CAPACITY (RX_CAPACITY)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.rx_byte      (rx_byte),
		.rx_timestamp (rx_timestamp),
		.full         (full),
		.push         (push),
		.push_job     (push_job)
	);

	twr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_job   (pop_job)
	);

	twr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job_valid  (pop_valid),
		.job        (pop_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.tx_time    (tx_time),
		.seq_number (seq_number),
		.last       (last)
	);

endmodule

@@ src/twr_front.sv @@
// ----------------------------------------------------------------------------
// twr_front
// Accepts input items, tracks the poll header byte by byte and queues one
// job per frame close (response, ignore, timeout or error).
// ----------------------------------------------------------------------------
module twr_front import twr_pkg::*; #(
	parameter int RX_CAPACITY = RX_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  rx_byte,
	input  logic [39:0] rx_timestamp,
	input  logic        full,
	output logic        push,
	output job_t        push_job
);

	logic [6:0] count_q;
	logic       match_q;
	logic       accept;
	logic       byte_ok;
	cmd_t       cmd;

	assign cmd      = cmd_t'(command);
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (cmd != CMD_BYTE);

	always_comb begin
		unique case (count_q)
			7'd0:    byte_ok = (rx_byte == FC_LO);
			7'd1:    byte_ok = (rx_byte == FC_HI);
			7'd3:    byte_ok = (rx_byte == cfg.pan_id[7:0]);
			7'd4:    byte_ok = (rx_byte == cfg.pan_id[15:8]);
			7'd5:    byte_ok = (rx_byte == cfg.own_address[7:0]);
			7'd6:    byte_ok = (rx_byte == cfg.own_address[15:8]);
			7'd7:    byte_ok = (rx_byte == cfg.own_address[23:16]);
			7'd8:    byte_ok = (rx_byte == cfg.own_address[31:24]);
			7'd9:    byte_ok = (rx_byte == POLL_FN);
			default: byte_ok = 1'b1;
		endcase
	end

	always_comb begin
		push_job.ts = rx_timestamp;
		unique case (cmd)
			CMD_END: push_job.kind = (match_q && count_q >= 7'(HDR_LEN)) ? KIND_RESP
				: KIND_IGNORE;
			CMD_TIMEOUT: push_job.kind = KIND_TIMEOUT;
			CMD_ERROR:   push_job.kind = KIND_ERROR;
			default:     push_job.kind = KIND_IGNORE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			match_q <= 1'b1;
		end else if (accept) begin
			if (cmd == CMD_BYTE) begin
				if (count_q >= 7'(RX_CAPACITY)) begin
					match_q <= 1'b0;
				end else if (count_q < 7'(HDR_LEN) && !byte_ok) begin
					match_q <= 1'b0;
				end
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 7'd1;
				end
			end else begin
				count_q <= '0;
				match_q <= 1'b1;
			end
		end
	end

endmodule

@@ src/twr_fifo.sv @@
// ----------------------------------------------------------------------------
// twr_fifo
// Small job queue between the frame front end and the response generator.
// ----------------------------------------------------------------------------
module twr_fifo import twr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_job   = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ src/twr_back.sv @@
// ----------------------------------------------------------------------------
// twr_back
// Takes queued jobs, computes the delayed transmit time and T3, and emits the
// response frame one byte per cycle unless stalled, or a single status item.
// ----------------------------------------------------------------------------
module twr_back import twr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic [32:0] tx_time,
	output logic [7:0]  seq_number,
	output logic        last
);

	logic        act_q;
	kind_t       cur_kind_q;
	logic [4:0]  idx_q;
	logic [32:0] ttime_q;
	logic [31:0] t2_q;
	logic [31:0] t3_q;
	logic [7:0]  seq_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic [32:0] time_q;
	logic [7:0]  oseq_q;
	logic        last_q;

	logic [40:0] sum;
	logic        adv;
	logic        is_last;
	logic        is_resp;
	logic [7:0]  resp_byte;

	assign sum     = {1'b0, job.ts} + {9'd0, cfg.reply_delay_uus, 16'd0};
	assign is_resp = (cur_kind_q == KIND_RESP);
	assign is_last = !is_resp || (idx_q == 5'(RESP_LEN - 1));
	assign adv     = act_q && (!out_valid_q || out_ready);
	assign pop     = job_valid && (!act_q || (adv && is_last));

	always_comb begin
		unique case (idx_q)
			5'd0:    resp_byte = FC_LO;
			5'd1:    resp_byte = FC_HI;
			5'd2:    resp_byte = seq_q;
			5'd3:    resp_byte = cfg.pan_id[7:0];
			5'd4:    resp_byte = cfg.pan_id[15:8];
			5'd5:    resp_byte = cfg.peer_address[7:0];
			5'd6:    resp_byte = cfg.peer_address[15:8];
			5'd7:    resp_byte = cfg.peer_address[23:16];
			5'd8:    resp_byte = cfg.peer_address[31:24];
			5'd9:    resp_byte = RESP_FN;
			5'd10:   resp_byte = t2_q[7:0];
			5'd11:   resp_byte = t2_q[15:8];
			5'd12:   resp_byte = t2_q[23:16];
			5'd13:   resp_byte = t2_q[31:24];
			5'd14:   resp_byte = t3_q[7:0];
			5'd15:   resp_byte = t3_q[15:8];
			5'd16:   resp_byte = t3_q[23:16];
			5'd17:   resp_byte = t3_q[31:24];
			default: resp_byte = 8'h00;
		endcase
	end

	// T3 settles in the cycle after the job loads, long before its bytes go out
	always_ff @(posedge clk) begin
		t3_q <= {ttime_q[23:1], 1'b0, 8'h00} + {16'd0, cfg.antenna_delay};
		if (pop) begin
			ttime_q <= sum[40:8];
			t2_q    <= job.ts[31:0];
		end
		if (adv) begin
			kind_q <= cur_kind_q;
			last_q <= is_last;
			if (is_resp) begin
				byte_q <= resp_byte;
				time_q <= ttime_q;
				oseq_q <= seq_q;
			end else begin
				byte_q <= '0;
				time_q <= '0;
				oseq_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			cur_kind_q  <= KIND_IGNORE;
			idx_q       <= '0;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				idx_q <= idx_q + 5'd1;
				if (is_last) begin
					act_q <= 1'b0;
					if (is_resp) begin
						seq_q <= seq_q + 8'd1;
					end
				end
			end
			if (pop) begin
				act_q      <= 1'b1;
				cur_kind_q <= job.kind;
				idx_q      <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign tx_byte    = byte_q;
	assign tx_time    = time_q;
	assign seq_number = oseq_q;
	assign last       = last_q;

endmodule

@@ src/twr_checker.sv @@
// ----------------------------------------------------------------------------
// twr_checker
// Port-level checks on the responder frame engine output stream.
// ----------------------------------------------------------------------------
`include "twr_responder_frame_engine_assert.svh"

module twr_checker import twr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  tx_byte,
	input logic [32:0] tx_time,
	input logic [7:0]  seq_number,
	input logic        last
);

	`TWR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(kind) && $stable(tx_byte) && $stable(tx_time) && $stable(last))

	`TWR_ASSERT_NOW(a_status_single, out_valid && kind != KIND_RESP, last)

	`TWR_ASSERT_NOW(a_status_clean, out_valid && kind != KIND_RESP,
		tx_byte == 8'h00 && tx_time == 33'd0 && seq_number == 8'h00)

	`TWR_ASSERT_NEXT(a_resp_burst, out_valid && out_ready && kind == KIND_RESP && !last,
		out_valid && kind == KIND_RESP && $stable(seq_number) && $stable(tx_time))

endmodule

bind twr_responder_frame_engine twr_checker u_twr_checker (.*);

@@ sim/tb_twr_responder_frame_engine.sv @@
// ----------------------------------------------------------------------------
// tb_twr_responder_frame_engine
// Self-checking bench for the ranging responder frame engine. Frames of poll
// bytes, frame ends, timeouts and errors are driven with random bursts and
// gaps. The output side stalls on a changing pattern. Each response item is
// predicted at input acceptance and compared field by field in order.
// Register settings are applied through the APB port between traffic phases
// and read back.
// ----------------------------------------------------------------------------
module tb_twr_responder_frame_engine;
	import twr_pkg::*;

	localparam int LIMIT  = 400000;
	localparam int SETTLE = 40;
	localparam int CAP    = RX_CAPACITY_DEF;

	typedef struct {
		kind_t       kind;
		logic [7:0]  tx_byte;
		logic [32:0] tx_time;
		logic [7:0]  seq;
		logic        last;
	} resp_item_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  rx_byte;
	logic [39:0] rx_timestamp;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic [32:0] tx_time;
	logic [7:0]  seq_number;
	logic        last;

	resp_item_t expected_tx_q[$];
	cfg_t       cur_cfg;
	int         exp_len;
	bit         frame_ok;
	logic [7:0] seq_ctr;

	int cycles;
	int err_cnt;
	int n_sent;
	int burst_left;
	bit idle_on;
	int hold_cycles;

	twr_responder_frame_engine uut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic note_mismatch(string what, logic [63:0] e, logic [63:0] a);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch %s: expected %0h got %0h", what, e, a);
	endtask

	// ---- response predictor ----
	function automatic logic [7:0] hdr_expect(int pos);
		case (pos)
			0: return FC_LO;
			1: return FC_HI;
			3: return cur_cfg.pan_id[7:0];
			4: return cur_cfg.pan_id[15:8];
			5: return cur_cfg.own_address[7:0];
			6: return cur_cfg.own_address[15:8];
			7: return cur_cfg.own_address[23:16];
			8: return cur_cfg.own_address[31:24];
			9: return POLL_FN;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic predict_frame_item(logic [1:0] c, logic [7:0] b, logic [39:0] t);
		resp_item_t r;
		logic [40:0] sum;
		logic [32:0] tt;
		logic [31:0] t3;
		logic [7:0]  f[RESP_LEN];
		r.kind = KIND_RESP;
		r.tx_byte = '0;
		r.tx_time = '0;
		r.seq = '0;
		r.last = 1'b1;
		case (c)
			CMD_BYTE: begin
				if (exp_len >= CAP)
					frame_ok = 1'b0;
				else if (exp_len < HDR_LEN && exp_len != 2 && b != hdr_expect(exp_len))
					frame_ok = 1'b0;
				if (exp_len < COUNT_MAX)
					exp_len++;
			end
			CMD_TIMEOUT, CMD_ERROR: begin
				r.kind = kind_t'(c);
				expected_tx_q.push_back(r);
				exp_len = 0;
				frame_ok = 1'b1;
			end
			default: begin
				if (!(frame_ok && exp_len >= HDR_LEN)) begin
					r.kind = KIND_IGNORE;
					expected_tx_q.push_back(r);
				end else begin
					sum = {1'b0, t} + (41'(cur_cfg.reply_delay_uus) << 16);
					tt = sum[40:8];
					t3 = {tt[23:1], 1'b0, 8'h00} + {16'h0, cur_cfg.antenna_delay};
					f[0] = FC_LO;
					f[1] = FC_HI;
					f[2] = seq_ctr;
					f[3] = cur_cfg.pan_id[7:0];
					f[4] = cur_cfg.pan_id[15:8];
					for (int k = 0; k < 4; k++) begin
						f[5 + k]  = cur_cfg.peer_address[8*k +: 8];
						f[10 + k] = t[8*k +: 8];
						f[14 + k] = t3[8*k +: 8];
					end
					f[9] = RESP_FN;
					f[18] = 8'h00;
					f[19] = 8'h00;
					for (int k = 0; k < RESP_LEN; k++) begin
						r.tx_byte = f[k];
						r.tx_time = tt;
						r.seq = seq_ctr;
						r.last = (k == RESP_LEN - 1);
						expected_tx_q.push_back(r);
					end
					seq_ctr++;
				end
				exp_len = 0;
				frame_ok = 1'b1;
			end
		endcase
	endtask

	task automatic check_tx_item();
		resp_item_t e;
		if (expected_tx_q.size() == 0) begin
			note_mismatch("unexpected item, kind", 64'hx, 64'(kind));
		end else begin
			e = expected_tx_q.pop_front();
			if (kind != e.kind)          note_mismatch("kind", 64'(e.kind), 64'(kind));
			if (tx_byte != e.tx_byte)    note_mismatch("tx_byte", 64'(e.tx_byte), 64'(tx_byte));
			if (tx_time != e.tx_time)    note_mismatch("tx_time", 64'(e.tx_time), 64'(tx_time));
			if (seq_number != e.seq)     note_mismatch("seq_number", 64'(e.seq), 64'(seq_number));
			if (last != e.last)          note_mismatch("last", 64'(e.last), 64'(last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_tx_item();
			if (in_valid && in_ready)
				predict_frame_item(command, rx_byte, rx_timestamp);
		end
	end

	// ---- output side stall pattern ----
	initial begin
		int mode_left;
		int phase;
		int rx_mode;
		mode_left = 0;
		phase = 0;
		rx_mode = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				if (mode_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				phase++;
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (phase % 4 != 3);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// ---- input side ----
	function automatic logic [39:0] rand_ts();
		return {8'($urandom), 32'($urandom)};
	endfunction

	task automatic send_item(cmd_t c, logic [7:0] b, logic [39:0] t);
		if (burst_left == 0) begin
			if (idle_on) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		command <= c;
		rx_byte <= b;
		rx_timestamp <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
	endtask

	// header bytes follow the current settings, one may be corrupted
	task automatic send_frame(int nbytes, int bad_pos, cmd_t close, logic [39:0] ts);
		logic [7:0] b;
		for (int k = 0; k < nbytes; k++) begin
			b = hdr_expect(k);
			if (k == bad_pos)
				b ^= 8'($urandom_range(1, 255));
			send_item(CMD_BYTE, b, rand_ts());
		end
		send_item(close, 8'($urandom), ts);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_tx_q.size() != 0) @(negedge clk);
	endtask

	task automatic apb_write(reg_idx_t r, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata != v)
			note_mismatch("register readback", 64'(v), 64'(prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_cfg(cfg_t c);
		drain_results();
		repeat (SETTLE) @(negedge clk);
		apb_write(REG_PAN,   {16'h0, c.pan_id});
		apb_write(REG_OWN,   c.own_address);
		apb_write(REG_PEER,  c.peer_address);
		apb_write(REG_ANT,   {16'h0, c.antenna_delay});
		apb_write(REG_DELAY, {16'h0, c.reply_delay_uus});
		cur_cfg = c;
	endtask

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.pan_id = 16'($urandom);
		c.own_address = $urandom;
		c.peer_address = $urandom;
		c.antenna_delay = 16'($urandom);
		c.reply_delay_uus = 16'($urandom);
		return c;
	endfunction

	// ---- tests ----
	task automatic test_directed_defaults();
		send_frame(HDR_LEN, -1, CMD_END, 40'h0);
		send_frame(3, -1, CMD_END, rand_ts());
		send_item(CMD_TIMEOUT, 8'hFF, 40'hFF_FFFF_FFFF);
		send_item(CMD_ERROR, 8'h00, 40'h0);
		send_item(CMD_END, 8'h00, rand_ts());
		send_frame(HDR_LEN, -1, CMD_END, 40'hFF_FFFF_FFFF);
	endtask

	task automatic test_register_extremes();
		write_cfg('0);
		send_frame(HDR_LEN, -1, CMD_END, 40'h0);
		send_frame(CAP, -1, CMD_END, 40'hFF_FFFF_FFFF);
		write_cfg('1);
		send_frame(HDR_LEN, -1, CMD_END, 40'hFF_FFFF_FFFF);
		send_frame(HDR_LEN, 9, CMD_END, rand_ts());
		send_frame(HDR_LEN + 2, -1, CMD_END, rand_ts());
	endtask

	task automatic test_backpressure();
		drain_results();
		idle_on = 1'b0;
		hold_cycles = 300;
		repeat (3) send_frame(HDR_LEN, -1, CMD_END, rand_ts());
		repeat (6) send_item(cmd_t'($urandom_range(CMD_TIMEOUT, CMD_ERROR)),
			8'($urandom), rand_ts());
		drain_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(int n_items);
		int stop_at;
		int pick;
		int pos;
		stop_at = n_sent + n_items;
		while (n_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				idle_on = !idle_on;
			if (pick < 55) begin
				send_frame($urandom_range(HDR_LEN, CAP), -1, CMD_END, rand_ts());
			end else if (pick < 65) begin
				pos = $urandom_range(0, 8);
				if (pos >= 2)
					pos++;
				send_frame($urandom_range(HDR_LEN, CAP), pos, CMD_END, rand_ts());
			end else if (pick < 73) begin
				send_frame($urandom_range(0, HDR_LEN - 1), -1, CMD_END, rand_ts());
			end else if (pick < 80) begin
				send_frame($urandom_range(CAP + 1, CAP + 8), -1, CMD_END, rand_ts());
			end else if (pick < 88) begin
				send_frame($urandom_range(0, CAP), -1,
					cmd_t'($urandom_range(CMD_TIMEOUT, CMD_ERROR)), rand_ts());
			end else begin
				send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), rand_ts());
			end
		end
	endtask

	task automatic test_capacity_edges();
		send_frame(CAP + 1, -1, CMD_END, rand_ts());
		send_frame(HDR_LEN - 1, -1, CMD_END, rand_ts());
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = CMD_BYTE;
		rx_byte = '0;
		rx_timestamp = '0;
		cycles = 0;
		err_cnt = 0;
		n_sent = 0;
		burst_left = 0;
		idle_on = 1'b1;
		hold_cycles = 0;
		cur_cfg = {PAN_ID_RST, OWN_ADDR_RST, PEER_ADDR_RST, ANT_DELAY_RST, REPLY_DLY_RST};
		exp_len = 0;
		frame_ok = 1'b1;
		seq_ctr = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_defaults();
		test_register_extremes();
		test_backpressure();
		test_capacity_edges();
		repeat (3) begin
			write_cfg(rand_cfg());
			test_random_traffic(20);
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0 && expected_tx_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
